// ===== rtl/csl_pkg.sv =====
// Shared types, constants and helper functions of the C subset lexer.
package csl_pkg;

   localparam int LINE_MAX_DEF = 255;
   localparam int QUEUE_DEPTH  = 4;
   localparam int KW_COUNT     = 9;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_STR,
      MODE_IDENT,
      MODE_PUNCT,
      MODE_SKIP
   } lex_mode_type;

   typedef enum logic [2:0] {
      KIND_NUM     = 3'd0,
      KIND_STR     = 3'd1,
      KIND_IDENT   = 3'd2,
      KIND_KEYWORD = 3'd3,
      KIND_PUNCT   = 3'd4,
      KIND_EOF     = 3'd5,
      KIND_ERROR   = 3'd6
   } token_kind_type;

   typedef logic [KW_COUNT-1:0] kw_mask_type;

   localparam kw_mask_type KW_ALL = '1;

   // return, if, else, for, while, int, sizeof, char, void
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd6, 3'd4, 3'd4
   };

   // right-justified text, first character in the highest used byte
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'("return"), 48'("if"), 48'("else"), 48'("for"), 48'("while"),
      48'("int"), 48'("sizeof"), 48'("char"), 48'("void")
   };

   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     start;
      logic [7:0]     len;
      logic [31:0]    value;
      logic [3:0]     kw;
      logic [7:0]     p1;
      logic [7:0]     p2;
   } token_type;

   typedef struct packed {
      token_type  tok0;
      token_type  tok1;
      logic [1:0] count;
      logic       eof;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic is_space(logic [7:0] b);
      return (b == 8'd32) || (b inside {[8'd9:8'd13]});
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha_u(logic [7:0] b);
      return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
   endfunction

   function automatic logic is_punct(logic [7:0] b);
      return (b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
   endfunction

   function automatic logic is_op(logic [7:0] b);
      return (b == CH_GT) || (b == CH_LT) || (b == CH_EQ) || (b == CH_BANG);
   endfunction

   function automatic logic [7:0] len_inc(logic [7:0] n);
      return (n == 8'hFF) ? n : n + 8'd1;
   endfunction

   function automatic kw_mask_type kw_filter(kw_mask_type mask, logic [7:0] pos,
                                             logic [7:0] b);
      kw_mask_type m;
      logic [2:0]  sh;
      m = mask;
      for (int k = 0; k < KW_COUNT; k++) begin
         sh = 3'(KW_LEN[k] - 3'd1 - pos[2:0]);
         if ((pos >= {5'd0, KW_LEN[k]}) || (KW_TEXT[k][8*sh +: 8] != b)) begin
            m[k] = 1'b0;
         end
      end
      return m;
   endfunction

   function automatic token_type make_tok(token_kind_type kind, logic [7:0] start,
                                          logic [7:0] len, logic [31:0] value,
                                          logic [3:0] kw, logic [7:0] p1,
                                          logic [7:0] p2);
      token_type t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.value = value;
      t.kw    = kw;
      t.p1    = p1;
      t.p2    = p2;
      return t;
   endfunction

   function automatic token_type ident_tok(logic [7:0] start, logic [7:0] len,
                                           kw_mask_type cand);
      token_type t;
      t = make_tok(KIND_IDENT, start, len, 32'd0, 4'd0, 8'd0, 8'd0);
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && (len == {5'd0, KW_LEN[k]})) begin
            t = make_tok(KIND_KEYWORD, start, len, 32'd0, 4'(k), 8'd0, 8'd0);
         end
      end
      return t;
   endfunction

endpackage

// ===== rtl/csl_front.sv =====
// Front end: lexes a byte per cycle unless q_stat.full; bundles each byte's tokens.
module csl_front import csl_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_char_byte,
   input  logic           req_line_end,
   input  logic           req_file_end,
   input  queue_stat_type q_stat,
   output logic           push,
   output bundle_type     bundle
);

   localparam logic [7:0] COL_LAST = 8'(LINE_MAX - 2);

   lex_mode_type mode_ff, mode_in;
   logic [7:0]   col_ff, col_in;
   logic [7:0]   start_ff, start_in;
   logic [7:0]   len_ff, len_in;
   logic [31:0]  value_ff, value_in;
   kw_mask_type  cand_ff, cand_in;
   logic [7:0]   held_ff, held_in;

   logic         accept;
   logic [7:0]   b;
   logic         eol;
   logic         c_digit, c_alnum, c_zero, c_quote, c_eq;
   logic         cont_num, cont_ident, cont_str;
   logic         close_v, used, start_v, flush_v;
   lex_mode_type mode2;
   logic [7:0]   start2, len2, held2;
   logic [31:0]  value2;
   kw_mask_type  cand2;
   token_type    close_tok, start_tok, flush_tok;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   // classify the byte against the token in progress
   always_comb begin
      b          = req_char_byte;
      eol        = req_line_end || req_file_end || (col_ff >= COL_LAST);
      c_digit    = is_digit(b);
      c_alnum    = c_digit || is_alpha_u(b);
      c_zero     = (b == CH_NUL);
      c_quote    = (b == CH_QUOTE);
      c_eq       = (b == CH_EQ);
      cont_num   = (mode_ff == MODE_NUM) && c_digit;
      cont_ident = (mode_ff == MODE_IDENT) && c_alnum;
      cont_str   = (mode_ff == MODE_STR) && !c_quote && !c_zero;
      close_v    = ((mode_ff == MODE_NUM) && !c_digit) ||
                   ((mode_ff == MODE_IDENT) && !c_alnum) ||
                   (mode_ff == MODE_PUNCT) ||
                   ((mode_ff == MODE_STR) && (c_quote || c_zero));
      used       = cont_num || cont_ident || ((mode_ff == MODE_PUNCT) && c_eq) ||
                   (mode_ff == MODE_STR) || (mode_ff == MODE_SKIP);

      if (cont_num) begin
         mode2 = MODE_NUM;
      end else if (cont_ident) begin
         mode2 = MODE_IDENT;
      end else if (cont_str) begin
         mode2 = MODE_STR;
      end else if (((mode_ff == MODE_STR) && c_zero) || (mode_ff == MODE_SKIP)) begin
         mode2 = MODE_SKIP;
      end else begin
         mode2 = MODE_IDLE;
      end
      start2  = start_ff;
      len2    = (cont_num || cont_ident || cont_str) ? len_inc(len_ff) : 8'd0;
      value2  = cont_num ? (value_ff << 3) + (value_ff << 1) + {24'd0, b - CH_ZERO}
                         : 32'd0;
      cand2   = cont_ident ? kw_filter(cand_ff, len_ff, b) : KW_ALL;
      held2   = 8'd0;
      start_v = 1'b0;

      if (!used) begin
         if (c_zero) begin
            mode2 = MODE_SKIP;
         end else if (is_space(b)) begin
            mode2 = MODE_IDLE;
         end else if (c_digit) begin
            mode2  = MODE_NUM;
            start2 = col_ff;
            len2   = 8'd1;
            value2 = {24'd0, b - CH_ZERO};
         end else if (c_quote) begin
            mode2  = MODE_STR;
            start2 = col_ff;
            len2   = 8'd0;
         end else if (is_alpha_u(b)) begin
            mode2  = MODE_IDENT;
            start2 = col_ff;
            len2   = 8'd1;
            cand2  = kw_filter(KW_ALL, 8'd0, b);
         end else if (is_op(b)) begin
            mode2  = MODE_PUNCT;
            start2 = col_ff;
            held2  = b;
         end else begin
            start_v = 1'b1;
         end
      end

      flush_v = eol && ((mode2 == MODE_NUM) || (mode2 == MODE_IDENT) ||
                        (mode2 == MODE_PUNCT) || (mode2 == MODE_STR));
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      col_in   = col_ff;
      start_in = start_ff;
      len_in   = len_ff;
      value_in = value_ff;
      cand_in  = cand_ff;
      held_in  = held_ff;
      if (accept) begin
         if (eol) begin
            mode_in  = MODE_IDLE;
            col_in   = 8'd0;
            start_in = req_file_end ? 8'd0 : start2;
            len_in   = 8'd0;
            value_in = 32'd0;
            cand_in  = KW_ALL;
            held_in  = 8'd0;
         end else begin
            mode_in  = mode2;
            col_in   = col_ff + 8'd1;
            start_in = start2;
            len_in   = len2;
            value_in = value2;
            cand_in  = cand2;
            held_in  = held2;
         end
      end
   end

   // tokens caused by this byte
   always_comb begin
      case (mode_ff)
         MODE_NUM: begin
            close_tok = make_tok(KIND_NUM, start_ff, len_ff, value_ff, 4'd0, 8'd0, 8'd0);
         end
         MODE_IDENT: begin
            close_tok = ident_tok(start_ff, len_ff, cand_ff);
         end
         MODE_PUNCT: begin
            close_tok = make_tok(KIND_PUNCT, start_ff, c_eq ? 8'd2 : 8'd1, 32'd0, 4'd0,
                                 held_ff, c_eq ? CH_EQ : 8'd0);
         end
         MODE_STR: begin
            close_tok = make_tok(c_quote ? KIND_STR : KIND_ERROR, start_ff, len_ff,
                                 32'd0, 4'd0, 8'd0, 8'd0);
         end
         default: begin
            close_tok = '0;
         end
      endcase

      start_tok = make_tok(is_punct(b) ? KIND_PUNCT : KIND_ERROR, col_ff, 8'd1, 32'd0,
                           4'd0, b, 8'd0);

      case (mode2)
         MODE_NUM: begin
            flush_tok = make_tok(KIND_NUM, start2, len2, value2, 4'd0, 8'd0, 8'd0);
         end
         MODE_IDENT: begin
            flush_tok = ident_tok(start2, len2, cand2);
         end
         MODE_PUNCT: begin
            flush_tok = make_tok(KIND_PUNCT, start2, 8'd1, 32'd0, 4'd0, held2, 8'd0);
         end
         MODE_STR: begin
            flush_tok = make_tok(KIND_ERROR, start2, len2, 32'd0, 4'd0, 8'd0, 8'd0);
         end
         default: begin
            flush_tok = '0;
         end
      endcase

      bundle.tok0  = close_v ? close_tok : (start_v ? start_tok : flush_tok);
      bundle.tok1  = start_v ? start_tok : flush_tok;
      bundle.count = 2'({1'b0, close_v} + {1'b0, start_v} + {1'b0, flush_v});
      bundle.eof   = req_file_end;
      push         = accept && ((bundle.count != 2'd0) || req_file_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         col_ff   <= 8'd0;
         start_ff <= 8'd0;
         len_ff   <= 8'd0;
         value_ff <= 32'd0;
         cand_ff  <= KW_ALL;
         held_ff  <= 8'd0;
      end else begin
         mode_ff  <= mode_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         value_ff <= value_in;
         cand_ff  <= cand_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== rtl/csl_queue.sv =====
// Short queue of token bundles between the front and back ends.
module csl_queue import csl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  bundle_type     push_data,
   input  logic           pop,
   output bundle_type     head,
   output queue_stat_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/csl_back.sv =====
// Back end: unpacks each bundle into single tokens behind an output register.
module csl_back import csl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  bundle_type     head,
   input  queue_stat_type q_stat,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output token_type      rsp_tok,
   output logic           rsp_last
);

   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   token_type  tok_ff;
   logic       last_ff;

   logic [1:0] total;
   logic       last;
   logic       load;
   token_type  sel_tok;

   always_comb begin
      total = 2'(head.count + {1'b0, head.eof});
      last  = (pos_ff == total - 2'd1);
      if (pos_ff < head.count) begin
         sel_tok = (pos_ff == 2'd0) ? head.tok0 : head.tok1;
      end else begin
         sel_tok = make_tok(KIND_EOF, 8'd0, 8'd0, 32'd0, 4'd0, 8'd0, 8'd0);
      end
      load     = !q_stat.empty && (!valid_ff || rsp_ready);
      pop      = load && last;
      pos_in   = load ? (last ? 2'd0 : pos_ff + 2'd1) : pos_ff;
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   assign rsp_valid = valid_ff;
   assign rsp_tok   = tok_ff;
   assign rsp_last  = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= sel_tok;
         last_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/c_subset_lexer.sv =====
// Top level of the byte-serial C subset lexer.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_ready  one source byte with line and file marks
//   rsp_     out        rsp_valid / rsp_ready  one token
//
// The front end takes one byte per cycle while the bundle queue has room.
// Each byte yields up to three tokens; the back end sends one token per cycle
// while rsp_ready is high, so bytes that cause several tokens let the queue fill
// and req_ready drop. A token passes the queue and then the output register.
// Reset is synchronous and clears lexer state, queue and output valid.
module c_subset_lexer import csl_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_line_end,
   input  logic        req_file_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [7:0]  rsp_start_column,
   output logic [7:0]  rsp_token_length,
   output logic [31:0] rsp_number_value,
   output logic [3:0]  rsp_keyword_index,
   output logic [7:0]  rsp_punct_first,
   output logic [7:0]  rsp_punct_second,
   output logic        rsp_last_of_run
);

   queue_stat_type q_stat;
   logic           push;
   logic           pop;
   bundle_type     push_data;
   bundle_type     head;
   token_type      rsp_tok;

   csl_front #(
      .LINE_MAX(LINE_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_byte(req_char_byte),
      .req_line_end (req_line_end),
      .req_file_end (req_file_end),
      .q_stat       (q_stat),
      .push         (push),
      .bundle       (push_data)
   );

   csl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   csl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tok  (rsp_tok),
      .rsp_last (rsp_last_of_run)
   );

   assign rsp_token_kind    = rsp_tok.kind;
   assign rsp_start_column  = rsp_tok.start;
   assign rsp_token_length  = rsp_tok.len;
   assign rsp_number_value  = rsp_tok.value;
   assign rsp_keyword_index = rsp_tok.kw;
   assign rsp_punct_first   = rsp_tok.p1;
   assign rsp_punct_second  = rsp_tok.p2;

endmodule

// ===== test/c_subset_lexer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for c_subset_lexer: directed and random source lines against a token scoreboard.
module c_subset_lexer_tb import csl_pkg::*; ();

   localparam int    LINE_CUT     = LINE_MAX_DEF - 2;
   localparam int    RANDOM_ITEMS = 180;
   localparam int    LONG_LINE    = 262;
   localparam int    HOLD_LONG    = 300;
   localparam int    DRAIN_MAX    = 5000;
   localparam string IDENT_POOL   =
      "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   localparam string OP_CHARS     = "<>=!";

   typedef logic [7:0] byte_line_type[$];

   typedef struct {
      token_kind_type kind;
      logic [7:0]     start;
      logic [7:0]     len;
      logic [31:0]    value;
      logic [3:0]     kw;
      logic [7:0]     p1;
      logic [7:0]     p2;
      logic           last;
   } lex_token_type;

   class token_board;
      lex_token_type pending_tokens[$];
      string         kw_word[KW_COUNT];
      lex_mode_type  mode;
      logic [7:0]    col;
      logic [7:0]    tstart;
      logic [7:0]    tlen;
      logic [7:0]    held;
      logic [31:0]   acc;
      kw_mask_type   cand;
      int            accepted;
      int            checked;
      int            errors;
      int            kind_seen[7];

      function new();
         kw_word = '{"return", "if", "else", "for", "while", "int", "sizeof", "char", "void"};
         clear_state();
      endfunction

      function void clear_token();
         mode = MODE_IDLE;
         tlen = 8'd0;
         acc  = 32'd0;
         cand = KW_ALL;
         held = 8'd0;
      endfunction

      function void clear_state();
         clear_token();
         col    = 8'd0;
         tstart = 8'd0;
      endfunction

      function bit is_blank(logic [7:0] b);
         return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
      endfunction

      function bit is_dec(logic [7:0] b);
         return b >= 8'h30 && b <= 8'h39;
      endfunction

      function bit is_word(logic [7:0] b);
         return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
      endfunction

      function bit is_mark(logic [7:0] b);
         return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
                (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
      endfunction

      function logic [7:0] sat_inc(logic [7:0] n);
         return (n == 8'hFF) ? n : n + 8'd1;
      endfunction

      function kw_mask_type narrow(kw_mask_type m, logic [7:0] pos, logic [7:0] b);
         for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= kw_word[k].len() || kw_word[k][pos] != b) m[k] = 1'b0;
         end
         return m;
      endfunction

      function void push(token_kind_type kind, logic [7:0] start, logic [7:0] len,
                         logic [31:0] value, logic [3:0] kw, logic [7:0] p1,
                         logic [7:0] p2);
         lex_token_type t;
         t.kind  = kind;
         t.start = start;
         t.len   = len;
         t.value = value;
         t.kw    = kw;
         t.p1    = p1;
         t.p2    = p2;
         t.last  = 1'b0;
         pending_tokens.push_back(t);
      endfunction

      function void push_word();
         for (int k = 0; k < KW_COUNT; k++) begin
            if (cand[k] && tlen == kw_word[k].len()) begin
               push(KIND_KEYWORD, tstart, tlen, 32'd0, 4'(k), 8'd0, 8'd0);
               return;
            end
         end
         push(KIND_IDENT, tstart, tlen, 32'd0, 4'd0, 8'd0, 8'd0);
      endfunction

      function void note_byte(logic [7:0] b, logic le, logic fe);
         logic [7:0]    c;
         bit            eol;
         bit            used;
         int            n_prior;
         lex_token_type t;
         c       = col;
         eol     = le || fe || (c >= LINE_CUT);
         used    = 1'b0;
         n_prior = pending_tokens.size();
         case (mode)
            MODE_NUM: begin
               if (is_dec(b)) begin
                  acc  = acc * 32'd10 + 32'(b - CH_ZERO);
                  tlen = sat_inc(tlen);
                  used = 1'b1;
               end else begin
                  push(KIND_NUM, tstart, tlen, acc, 4'd0, 8'd0, 8'd0);
                  clear_token();
               end
            end
            MODE_IDENT: begin
               if (is_word(b) || is_dec(b)) begin
                  cand = narrow(cand, tlen, b);
                  tlen = sat_inc(tlen);
                  used = 1'b1;
               end else begin
                  push_word();
                  clear_token();
               end
            end
            MODE_PUNCT: begin
               used = (b == CH_EQ);
               push(KIND_PUNCT, tstart, used ? 8'd2 : 8'd1, 32'd0, 4'd0, held,
                    used ? CH_EQ : 8'd0);
               clear_token();
            end
            MODE_STR: begin
               used = 1'b1;
               if (b == CH_QUOTE) begin
                  push(KIND_STR, tstart, tlen, 32'd0, 4'd0, 8'd0, 8'd0);
                  clear_token();
               end else if (b == CH_NUL) begin
                  push(KIND_ERROR, tstart, tlen, 32'd0, 4'd0, 8'd0, 8'd0);
                  clear_token();
                  mode = MODE_SKIP;
               end else begin
                  tlen = sat_inc(tlen);
               end
            end
            MODE_SKIP: used = 1'b1;
            default: clear_token();
         endcase

         if (!used) begin
            if (b == CH_NUL) begin
               mode = MODE_SKIP;
            end else if (is_dec(b)) begin
               mode   = MODE_NUM;
               tstart = c;
               tlen   = 8'd1;
               acc    = 32'(b - CH_ZERO);
            end else if (b == CH_QUOTE) begin
               mode   = MODE_STR;
               tstart = c;
               tlen   = 8'd0;
            end else if (is_word(b)) begin
               mode   = MODE_IDENT;
               tstart = c;
               cand   = narrow(KW_ALL, 8'd0, b);
               tlen   = 8'd1;
            end else if (b == CH_GT || b == CH_LT || b == CH_EQ || b == CH_BANG) begin
               mode   = MODE_PUNCT;
               tstart = c;
               held   = b;
            end else if (is_mark(b)) begin
               push(KIND_PUNCT, c, 8'd1, 32'd0, 4'd0, b, 8'd0);
            end else if (!is_blank(b)) begin
               push(KIND_ERROR, c, 8'd1, 32'd0, 4'd0, b, 8'd0);
            end
         end

         if (eol) begin
            case (mode)
               MODE_NUM:   push(KIND_NUM, tstart, tlen, acc, 4'd0, 8'd0, 8'd0);
               MODE_IDENT: push_word();
               MODE_PUNCT: push(KIND_PUNCT, tstart, 8'd1, 32'd0, 4'd0, held, 8'd0);
               MODE_STR:   push(KIND_ERROR, tstart, tlen, 32'd0, 4'd0, 8'd0, 8'd0);
               default: ;
            endcase
            clear_token();
            col = 8'd0;
         end else begin
            col = c + 8'd1;
         end

         if (fe) begin
            push(KIND_EOF, 8'd0, 8'd0, 32'd0, 4'd0, 8'd0, 8'd0);
            clear_state();
         end

         if (pending_tokens.size() > n_prior) begin
            t      = pending_tokens.pop_back();
            t.last = 1'b1;
            pending_tokens.push_back(t);
         end
         accepted++;
      endfunction

      function bit field_differs(string name, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v === want_v) return 1'b0;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
         return 1'b1;
      endfunction

      function void check_token(lex_token_type got);
         lex_token_type want;
         bit            bad;
         if (pending_tokens.size() == 0) begin
            $display("%0t: token kind %0h at column %0d with nothing outstanding",
                     $time, got.kind, got.start);
            errors++;
            return;
         end
         want = pending_tokens.pop_front();
         bad  = 1'b0;
         bad |= field_differs("token_kind", want.kind, got.kind);
         bad |= field_differs("start_column", want.start, got.start);
         bad |= field_differs("token_length", want.len, got.len);
         bad |= field_differs("number_value", want.value, got.value);
         bad |= field_differs("keyword_index", want.kw, got.kw);
         bad |= field_differs("punct_first", want.p1, got.p1);
         bad |= field_differs("punct_second", want.p2, got.p2);
         bad |= field_differs("last_of_run", want.last, got.last);
         if (bad) errors++;
         checked++;
         kind_seen[want.kind]++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_byte;
   logic        req_line_end;
   logic        req_file_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_token_kind;
   logic [7:0]  rsp_start_column;
   logic [7:0]  rsp_token_length;
   logic [31:0] rsp_number_value;
   logic [3:0]  rsp_keyword_index;
   logic [7:0]  rsp_punct_first;
   logic [7:0]  rsp_punct_second;
   logic        rsp_last_of_run;

   token_board board;
   bit         quiet_send;

   c_subset_lexer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .req_line_end      (req_line_end),
      .req_file_end      (req_file_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_start_column  (rsp_start_column),
      .rsp_token_length  (rsp_token_length),
      .rsp_number_value  (rsp_number_value),
      .rsp_keyword_index (rsp_keyword_index),
      .rsp_punct_first   (rsp_punct_first),
      .rsp_punct_second  (rsp_punct_second),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic byte_line_type from_text(string s);
      byte_line_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] blank_byte();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : 8'd32;
   endfunction

   function automatic void add_fragment(ref byte_line_type q);
      int         r;
      int         n;
      string      w;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         w = board.kw_word[$urandom_range(0, KW_COUNT - 1)];
         case ($urandom_range(0, 5))
            0: w = {w, "s"};
            1: w = w.substr(0, w.len() - 2);
            default: ;
         endcase
         for (int i = 0; i < w.len(); i++) q.push_back(w[i]);
      end else if (r < 40) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) q.push_back(IDENT_POOL[$urandom_range(0, i == 0 ? 52 : 62)]);
      end else if (r < 55) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
         for (int i = 0; i < n; i++) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 65) begin
         q.push_back(CH_QUOTE);
         if ($urandom_range(0, 3) == 0) begin
            w = board.kw_word[$urandom_range(0, KW_COUNT - 1)];
            for (int i = 0; i < w.len(); i++) q.push_back(w[i]);
         end else begin
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom_range(32, 126));
               q.push_back(b == CH_QUOTE ? 8'h27 : b);
            end
         end
         if ($urandom_range(0, 5) != 0) q.push_back(CH_QUOTE);
      end else if (r < 80) begin
         q.push_back(OP_CHARS[$urandom_range(0, 3)]);
         if ($urandom_range(0, 1) == 0) q.push_back(CH_EQ);
      end else if (r < 92) begin
         b = 8'($urandom_range(33, 126));
         if (board.is_word(b) || board.is_dec(b) || b == CH_QUOTE) b = 8'h3B;
         q.push_back(b);
      end else begin
         q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) < 6) q.push_back(blank_byte());
   endfunction

   task automatic send_byte(logic [7:0] b, logic le, logic fe);
      int gap;
      gap = pick_gap(quiet_send);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= b;
      req_line_end  <= le;
      req_file_end  <= fe;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      board.note_byte(b, le, fe);
   endtask

   task automatic send_line(byte_line_type q, logic le, logic fe);
      for (int i = 0; i < q.size(); i++)
         send_byte(q[i], le && i == q.size() - 1, fe && i == q.size() - 1);
   endtask

   always @(posedge clock) begin : rsp_watch
      lex_token_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.kind  = token_kind_type'(rsp_token_kind);
         got.start = rsp_start_column;
         got.len   = rsp_token_length;
         got.value = rsp_number_value;
         got.kw    = rsp_keyword_index;
         got.p1    = rsp_punct_first;
         got.p2    = rsp_punct_second;
         got.last  = rsp_last_of_run;
         board.check_token(got);
      end
   end

   initial begin : rsp_side
      int stall;
      bit held_once;
      held_once = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_once && board.accepted >= 100) begin
            held_once = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_LONG) @(posedge clock);
         end else begin
            stall = pick_gap($urandom_range(0, 4) == 0);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #800000;
      $display("c_subset_lexer test failed");
      $finish;
   end

   initial begin : stimulus
      byte_line_type q;
      int            sent;
      int            len_goal;
      int            drain;
      bit            fe;
      board         = new();
      quiet_send    = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_char_byte <= 8'd0;
      req_line_end  <= 1'b0;
      req_file_end  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_line(from_text("if>=9"), 1'b1, 1'b0);
      send_line({8'hFF, 8'h01, 8'h37, CH_NUL, 8'h7A}, 1'b1, 1'b0);
      send_line({CH_QUOTE, 8'h71, CH_NUL, CH_BANG}, 1'b1, 1'b0);
      send_line({CH_QUOTE, 8'h09}, 1'b1, 1'b0);
      send_line(from_text("<=!===<"), 1'b1, 1'b0);
      send_line(from_text("\"s\""), 1'b0, 1'b1);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         q = {};
         len_goal = $urandom_range(1, 14);
         while (q.size() < len_goal) add_fragment(q);
         quiet_send = ($urandom_range(0, 5) == 0);
         fe = ($urandom_range(0, 9) == 0);
         send_line(q, fe ? 1'($urandom_range(0, 1)) : 1'b1, fe);
         sent += q.size();
         if (sent >= 60 && sent - q.size() < 60) begin
            q = {};
            while (q.size() < LONG_LINE) add_fragment(q);
            send_line(q, 1'b1, 1'b0);
         end
      end
      send_line({8'h7D}, 1'b1, 1'b1);
      req_valid <= 1'b0;

      drain = 0;
      while (board.pending_tokens.size() > 0 && drain < DRAIN_MAX) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (board.pending_tokens.size() > 0) begin
         $display("%0t: %0d tokens never arrived", $time, board.pending_tokens.size());
         board.errors++;
      end

      $display("Lexed %0d bytes into %0d tokens: %0d numbers, %0d strings, %0d identifiers,",
               board.accepted, board.checked, board.kind_seen[KIND_NUM],
               board.kind_seen[KIND_STR], board.kind_seen[KIND_IDENT]);
      $display("%0d keywords, %0d punctuation, %0d end-of-file, %0d error tokens; %0d mismatches",
               board.kind_seen[KIND_KEYWORD], board.kind_seen[KIND_PUNCT],
               board.kind_seen[KIND_EOF], board.kind_seen[KIND_ERROR], board.errors);
      if (board.errors == 0) begin
         $display("c_subset_lexer test passed");
      end else begin
         $display("c_subset_lexer test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/csl_pkg.sv
rtl/csl_front.sv
rtl/csl_queue.sv
rtl/csl_back.sv
rtl/c_subset_lexer.sv
test/c_subset_lexer_tb.sv
